FILE: rtl/pnguf_pkg.sv
// Shared types, register indexes and constants for the PNG scanline unfilter.
package pnguf_pkg;

	localparam int PNGUF_MAX_WIDTH = 1024;
	localparam int PNGUF_ADDR_W    = 3;
	localparam int PNGUF_DATA_W    = 32;

	// Register indexes, taken from address bit 2.
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// Highest filter type code that the format defines.
	localparam logic [7:0] FILTER_MAX = 8'd4;

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filter_t;

	typedef struct packed {
		logic [10:0] image_width;
		logic [15:0] image_height;
	} cfg_t;

endpackage

FILE: rtl/pnguf_in_if.sv
// Valid/ready channel that carries the filtered byte stream.
interface pnguf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

FILE: rtl/pnguf_out_if.sv
// Valid/ready channel that carries reconstructed pixel bytes.
interface pnguf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_byte;
	logic [1:0] channel;
	logic       row_end;
	logic       image_end;
	logic       bad_filter;

	modport source (output valid, output pixel_byte, output channel, output row_end,
		output image_end, output bad_filter, input ready);
	modport sink (input valid, input pixel_byte, input channel, input row_end,
		input image_end, input bad_filter, output ready);
endinterface

FILE: rtl/pnguf_cfg_regs.sv
// APB-style register file holding image width and height.
module pnguf_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [pnguf_pkg::PNGUF_ADDR_W-1:0]   paddr,
	input  logic [pnguf_pkg::PNGUF_DATA_W-1:0]   pwdata,
	output logic [pnguf_pkg::PNGUF_DATA_W-1:0]   prdata,
	output logic                                 pready,
	output pnguf_pkg::cfg_t                      cfg
);
	import pnguf_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= 11'd1;
			cfg_q.image_height <= 16'd1;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= pwdata[10:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_IMAGE_WIDTH:  prdata = {21'd0, cfg_q.image_width};
			REG_IMAGE_HEIGHT: prdata = {16'd0, cfg_q.image_height};
			default:          prdata = '0;
		endcase
	end

endmodule

FILE: rtl/pnguf_line_store.sv
// Previous-row byte memory: one write and one registered read port.
module pnguf_line_store #(
	parameter int DEPTH = 4 * pnguf_pkg::PNGUF_MAX_WIDTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/pnguf_predict.sv
// Filter predictor and modular add that rebuild one byte.
module pnguf_predict (
	input  pnguf_pkg::filter_t filter,
	input  logic [7:0]         raw,
	input  logic [7:0]         a,
	input  logic [7:0]         b,
	input  logic [7:0]         c,
	output logic [7:0]         recon
);
	import pnguf_pkg::*;

	logic [7:0] pa;
	logic [7:0] pb;
	logic [8:0] pc;
	logic [8:0] sum_ab;
	logic [8:0] two_c;
	logic [7:0] paeth;
	logic [7:0] pred;

	assign sum_ab = {1'b0, a} + {1'b0, b};
	assign two_c  = {c, 1'b0};
	assign pa     = (b > c) ? b - c : c - b;
	assign pb     = (a > c) ? a - c : c - a;
	assign pc     = (sum_ab > two_c) ? sum_ab - two_c : two_c - sum_ab;

	// Ties go to a, then b, as the format requires.
	always_comb begin
		if (pa <= pb && {1'b0, pa} <= pc) begin
			paeth = a;
		end else if ({1'b0, pb} <= pc) begin
			paeth = b;
		end else begin
			paeth = c;
		end
	end

	always_comb begin
		unique case (filter)
			FILT_SUB:   pred = a;
			FILT_UP:    pred = b;
			FILT_AVG:   pred = sum_ab[8:1];
			FILT_PAETH: pred = paeth;
			default:    pred = 8'd0;
		endcase
	end

	assign recon = raw + pred;

endmodule

FILE: rtl/png_scanline_unfilter.sv
// Top level of the PNG scanline unfilter for 8-bit RGBA images.
//
// Channel   Dir  Handshake      Payload
// stream    in   valid/ready    stream_byte[7:0]: filter type, then row bytes
// pixels    out  valid/ready    pixel_byte, channel, row_end, image_end, bad_filter
// apb       in   psel/penable   image_width (addr 0), image_height (addr 4)
//
// One stream byte is taken every cycle, filter bytes included, unless both
// stages are full and pixels stalls. A pixel byte passes the compute stage,
// which takes the line store read, then the output register. Asynchronous reset
// clears all control state; the line store has no reset and needs no clearing
// pass, as the first row of every image ignores it. When pixels stalls, the
// output register holds and one more byte still enters the compute stage.
module png_scanline_unfilter #(
	parameter int MAX_WIDTH = pnguf_pkg::PNGUF_MAX_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	pnguf_in_if.sink                           stream,
	pnguf_out_if.source                        pixels,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pnguf_pkg::PNGUF_ADDR_W-1:0] paddr,
	input  logic [pnguf_pkg::PNGUF_DATA_W-1:0] pwdata,
	output logic [pnguf_pkg::PNGUF_DATA_W-1:0] prdata,
	output logic                               pready
);
	import pnguf_pkg::*;

	localparam int DEPTH = 4 * MAX_WIDTH;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int WE_W  = $clog2(MAX_WIDTH + 1);
	localparam int BP_W  = WE_W + 2;

	cfg_t cfg;

	// Row and image position, updated as each transaction is accepted.
	logic [BP_W-1:0]  byte_pos_q;
	logic [15:0]      row_cnt_q;
	logic             first_row_q;
	filter_t          row_filter_q;
	logic             filter_err_q;

	// Channels of the previous pixel in this row and in the row above.
	logic [31:0]      left_q;
	logic [31:0]      uleft_q;

	// Compute stage: line store data arrives here.
	logic             valid_s1;
	logic [7:0]       raw_s1;
	logic [IDX_W-1:0] idx_s1;
	filter_t          filt_s1;
	logic             err_s1;
	logic             first_s1;
	logic             pix0_s1;
	logic             rend_s1;
	logic             iend_s1;

	// Output register.
	logic             valid_s2;
	logic [7:0]       pixel_s2;
	logic [1:0]       chan_s2;
	logic             rend_s2;
	logic             iend_s2;
	logic             bad_s2;

	logic [WE_W-1:0]  w_eff;
	logic [BP_W-1:0]  row_bytes;
	logic [15:0]      h_eff;
	logic             in_fire;
	logic             is_filter;
	logic             row_last;
	logic             img_last;
	logic [IDX_W-1:0] idx;
	logic             load_s1;
	logic             adv_s1;
	logic             fire_s1;
	logic [7:0]       mem_rd_data;
	logic [1:0]       ch_s1;
	logic [7:0]       a_s1;
	logic [7:0]       b_s1;
	logic [7:0]       c_s1;
	logic [7:0]       recon_s1;

	pnguf_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// A width of zero acts as one pixel and widths past the store are clamped.
	always_comb begin
		if (cfg.image_width == 11'd0) begin
			w_eff = WE_W'(1);
		end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
			w_eff = WE_W'(MAX_WIDTH);
		end else begin
			w_eff = WE_W'(cfg.image_width);
		end
	end

	assign row_bytes = {w_eff, 2'b00};
	assign h_eff     = (cfg.image_height == 16'd0) ? 16'd1 : cfg.image_height;

	assign is_filter = (byte_pos_q == '0);
	assign row_last  = (byte_pos_q >= row_bytes);
	assign img_last  = ({1'b0, row_cnt_q} + 17'd1) >= {1'b0, h_eff};
	assign idx       = IDX_W'(byte_pos_q - BP_W'(1));

	// The compute stage drains into the output register whenever that register
	// is empty or being emptied, so input only waits on a full, stalled pair.
	assign adv_s1       = !valid_s2 || pixels.ready;
	assign stream.ready = !valid_s1 || adv_s1;
	assign in_fire      = stream.valid && stream.ready;
	assign load_s1      = in_fire && !is_filter;
	assign fire_s1      = valid_s1 && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q   <= '0;
			row_cnt_q    <= '0;
			first_row_q  <= 1'b1;
			row_filter_q <= FILT_NONE;
			filter_err_q <= 1'b0;
		end else if (in_fire) begin
			if (is_filter) begin
				// Unknown filter types fall back to None and mark the row.
				filter_err_q <= (stream.stream_byte > FILTER_MAX);
				row_filter_q <= (stream.stream_byte > FILTER_MAX) ? FILT_NONE
					: filter_t'(stream.stream_byte[2:0]);
				byte_pos_q   <= BP_W'(1);
			end else if (row_last) begin
				byte_pos_q <= '0;
				if (img_last) begin
					row_cnt_q   <= '0;
					first_row_q <= 1'b1;
				end else begin
					row_cnt_q   <= row_cnt_q + 16'd1;
					first_row_q <= 1'b0;
				end
			end else begin
				byte_pos_q <= byte_pos_q + BP_W'(1);
			end
		end
	end

	// The read is issued as the byte is accepted; the data is consumed in the
	// following cycle and held while the stage is stalled, since no new read
	// starts until the stage moves on. The entry is written back as the byte
	// leaves the compute stage, after its read data has been taken, and is not
	// read again until the next row.
	pnguf_line_store #(
		.DEPTH (DEPTH),
		.AW    (IDX_W)
	) u_store (
		.clk     (clk),
		.rd_en   (load_s1),
		.rd_addr (idx),
		.rd_data (mem_rd_data),
		.wr_en   (fire_s1),
		.wr_addr (idx_s1),
		.wr_data (recon_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			raw_s1   <= stream.stream_byte;
			idx_s1   <= idx;
			filt_s1  <= row_filter_q;
			err_s1   <= filter_err_q;
			first_s1 <= first_row_q;
			pix0_s1  <= (byte_pos_q <= BP_W'(4));
			rend_s1  <= row_last;
			iend_s1  <= row_last && img_last;
		end
	end

	// The first pixel of a row has no left or upper-left neighbor, and the
	// first row of an image has nothing above it.
	assign ch_s1 = idx_s1[1:0];
	assign a_s1  = pix0_s1 ? 8'd0 : left_q[ch_s1*8 +: 8];
	assign c_s1  = pix0_s1 ? 8'd0 : uleft_q[ch_s1*8 +: 8];
	assign b_s1  = first_s1 ? 8'd0 : mem_rd_data;

	pnguf_predict u_predict (
		.filter (filt_s1),
		.raw    (raw_s1),
		.a      (a_s1),
		.b      (b_s1),
		.c      (c_s1),
		.recon  (recon_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			uleft_q <= '0;
		end else if (fire_s1) begin
			left_q[ch_s1*8 +: 8]  <= recon_s1;
			uleft_q[ch_s1*8 +: 8] <= b_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			pixel_s2 <= recon_s1;
			chan_s2  <= ch_s1;
			rend_s2  <= rend_s1;
			iend_s2  <= iend_s1;
			bad_s2   <= err_s1;
		end
	end

	assign pixels.valid      = valid_s2;
	assign pixels.pixel_byte = pixel_s2;
	assign pixels.channel    = chan_s2;
	assign pixels.row_end    = rend_s2;
	assign pixels.image_end  = iend_s2;
	assign pixels.bad_filter = bad_s2;

	// The line store never sees a read and a write of one entry together.
	a_store_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(load_s1 && fire_s1) |-> (idx != idx_s1))
		else $error("line store read and write hit the same entry");

	// Input waits only when both the compute stage and the output are full.
	a_ready_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!stream.ready |-> (valid_s1 && valid_s2 && !pixels.ready))
		else $error("input stalled while the pipeline had room");

	// The end of an image is always also the end of a row.
	a_image_end_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && iend_s1) |-> rend_s1)
		else $error("image end without row end");

	// A filter byte never enters the compute stage.
	a_filter_not_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && is_filter && !valid_s1) |=> !valid_s1)
		else $error("filter byte produced a result");

endmodule
